// File: rtl/core/byte_budget_lru_cache_directory_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the byte-budget LRU cache directory
// Shared macros for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BYTE_BUDGET_LRU_CACHE_DIRECTORY_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication under reset
`define BBLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset
`define BBLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bblc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bblc_pkg
// Types and constants of the byte-budget LRU cache directory.
// ---------------------------------------------------------------------------
package bblc_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned KLEN_W   = 13;
	localparam int unsigned PLEN_W   = 31;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned BYTES_W  = 32;
	localparam int unsigned OVH_W    = 8;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned EVCNT_W  = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTES_W-1:0] RESET_CAPACITY  = 32'(200 * (1 << 20));
	localparam logic [BYTES_W-1:0] RESET_MAX_ENTRY = 32'(10 * (1 << 20));
	localparam logic [OVH_W-1:0]   RESET_OVERHEAD  = 8'd40;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD  = 2'd2;

	// commands
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd3;

	// one directory record as held in the entry memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TIME_W-1:0]  stamp;
		logic [BYTES_W-1:0] charge;
		logic [31:0]        order;
		logic [PLEN_W-1:0]  plen;
	} entry_rec_t;

	// sequencer states
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_CHECK   = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_RESOLVE = 7'b0001000,
		ST_FREE    = 7'b0010000,
		ST_WRITE   = 7'b0100000,
		ST_DONE    = 7'b1000000
	} state_t;

endpackage

// File: rtl/core/bblc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bblc channel interfaces
// Valid/ready channels for commands into and results out of the directory.
// ---------------------------------------------------------------------------
interface bblc_cmd_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [bblc_pkg::KEY_W-1:0]          key_tag;
	logic [bblc_pkg::KLEN_W-1:0]         key_length;
	logic [bblc_pkg::PLEN_W-1:0]         entry_length;
	logic [bblc_pkg::TIME_W-1:0]         now;

	modport source (output valid, command, key_tag, key_length, entry_length, now,
		input ready);
	modport sink (input valid, command, key_tag, key_length, entry_length, now,
		output ready);
endinterface

interface bblc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [bblc_pkg::STATUS_W-1:0]       status;
	logic [bblc_pkg::SLOT_W-1:0]         slot;
	logic [bblc_pkg::PLEN_W-1:0]         hit_length;
	logic [bblc_pkg::EVCNT_W-1:0]        evicted_count;

	modport source (output valid, status, slot, hit_length, evicted_count, input ready);
	modport sink (input valid, status, slot, hit_length, evicted_count, output ready);
endinterface

// File: rtl/core/byte_budget_lru_cache_directory.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// Size-aware LRU directory: lookups stamp the newest matching key, inserts
// evict oldest-stamp entries until the charge fits the byte budget and a slot is free.
// ---------------------------------------------------------------------------
// Lookup: one full pass over the entry memory from transfer to result valid,
//   one read per cycle, compare on the registered read in the next cycle.
// Insert: rejected when over the entry limit; else one full pass per eviction,
//   then budget check, free-slot search, write and result.
// One command at a time; the result register lets the next command transfer in.
// Reset clears valid bits, byte count and insert sequence, restores config defaults.
`include "byte_budget_lru_cache_directory_defines.svh"

module byte_budget_lru_cache_directory #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bblc_cmd_if.sink                          cmd,
	bblc_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [bblc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bblc_pkg::BYTES_W-1:0]      cfg_data
);

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	// configuration
	logic [31:0] cap_q, max_q;
	logic [7:0]  ovh_q;

	// command latched at transfer
	logic        cmd_q;
	logic [63:0] key_q;
	logic [30:0] plen_q;
	logic [31:0] now_q;
	logic [32:0] charge_q;

	// directory bookkeeping
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      cnt_q;
	logic [31:0]        used_q;
	logic [31:0]        seq_q;

	bblc_pkg::state_t state_q;

	// scan pipeline
	logic [IW-1:0] idx_q;
	logic          iss_q;
	logic          go_s1, last_s1, vld_s1;
	logic [IW-1:0] idx_s1;
	bblc_pkg::entry_rec_t rd_s1;

	// best candidate of the current scan
	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [31:0]          best_age_q;
	bblc_pkg::entry_rec_t best_rec_q;

	// result being built and result register
	logic [1:0]   res_status_q;
	logic [IW-1:0] res_slot_q;
	logic [30:0]  res_hit_q;
	logic [CW-1:0] ev_q;
	logic         rsp_valid_q;
	logic [1:0]   rsp_status_q;
	logic [5:0]   rsp_slot_q;
	logic [30:0]  rsp_hit_q;
	logic [6:0]   rsp_ev_q;

	// entry memory
	bblc_pkg::entry_rec_t mem_q [ENTRIES];
	logic                 mem_we;
	logic [IW-1:0]        mem_wa;
	bblc_pkg::entry_rec_t mem_wd;

	logic        cmd_xfer;
	logic [31:0] age_c;
	logic        take_c;
	logic        over_c;
	logic [32:0] charge_c;

	assign cmd.ready     = (state_q == bblc_pkg::ST_IDLE);
	assign cmd_xfer      = cmd.valid && cmd.ready;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.slot      = rsp_slot_q;
	assign rsp.hit_length = rsp_hit_q;
	assign rsp.evicted_count = rsp_ev_q;

	// charge of an insert and budget check
	assign charge_c = 33'(cmd.entry_length) + 33'(cmd.key_length) + 33'd1 + 33'(ovh_q);
	assign over_c   = (34'(used_q) + 34'(charge_q)) > 34'(cap_q);

	// candidate compare on the registered memory read
	assign age_c = seq_q - rd_s1.order;
	always_comb begin
		if (cmd_q == bblc_pkg::CMD_LOOKUP) begin
			take_c = vld_s1 && (rd_s1.key == key_q) && (!found_q || age_c < best_age_q);
		end else begin
			take_c = vld_s1 && (!found_q || rd_s1.stamp < best_rec_q.stamp ||
				(rd_s1.stamp == best_rec_q.stamp && age_c < best_age_q));
		end
	end

	// memory write port: stamp update on hit, new record on insert
	always_comb begin
		mem_we = 1'b0;
		mem_wa = best_idx_q;
		mem_wd = best_rec_q;
		if (state_q == bblc_pkg::ST_RESOLVE && cmd_q == bblc_pkg::CMD_LOOKUP && found_q) begin
			mem_we       = 1'b1;
			mem_wd.stamp = now_q;
		end else if (state_q == bblc_pkg::ST_WRITE) begin
			mem_we = 1'b1;
			mem_wa = idx_q;
			mem_wd = '{key: key_q, stamp: now_q, charge: charge_q[31:0],
				order: seq_q, plen: plen_q};
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_s1 <= mem_q[idx_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bblc_pkg::RESET_CAPACITY;
			max_q <= bblc_pkg::RESET_MAX_ENTRY;
			ovh_q <= bblc_pkg::RESET_OVERHEAD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bblc_pkg::CFG_CAPACITY:  cap_q <= cfg_data;
				bblc_pkg::CFG_MAX_ENTRY: max_q <= cfg_data;
				bblc_pkg::CFG_OVERHEAD:  ovh_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// command payload and scan pipeline registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_q    <= cmd.command;
			key_q    <= cmd.key_tag;
			plen_q   <= cmd.entry_length;
			now_q    <= cmd.now;
			charge_q <= charge_c;
		end
		vld_s1 <= valid_q[idx_q];
		idx_s1 <= idx_q;
		last_s1 <= (idx_q == LAST_IDX);
		if (go_s1 && take_c) begin
			best_idx_q <= idx_s1;
			best_age_q <= age_c;
			best_rec_q <= rd_s1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bblc_pkg::ST_IDLE;
			valid_q      <= '0;
			cnt_q        <= '0;
			used_q       <= '0;
			seq_q        <= '0;
			idx_q        <= '0;
			iss_q        <= 1'b0;
			go_s1        <= 1'b0;
			found_q      <= 1'b0;
			res_status_q <= bblc_pkg::STATUS_MISS;
			res_slot_q   <= '0;
			res_hit_q    <= '0;
			ev_q         <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= bblc_pkg::STATUS_MISS;
			rsp_slot_q   <= '0;
			rsp_hit_q    <= '0;
			rsp_ev_q     <= '0;
		end else begin
			go_s1 <= iss_q;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				bblc_pkg::ST_IDLE: begin
					if (cmd_xfer) begin
						res_status_q <= bblc_pkg::STATUS_MISS;
						res_slot_q   <= '0;
						res_hit_q    <= '0;
						ev_q         <= '0;
						idx_q        <= '0;
						found_q      <= 1'b0;
						if (cmd.command == bblc_pkg::CMD_LOOKUP) begin
							iss_q   <= 1'b1;
							state_q <= bblc_pkg::ST_SCAN;
						end else if (charge_c > 33'(max_q)) begin
							res_status_q <= bblc_pkg::STATUS_REJECTED;
							state_q      <= bblc_pkg::ST_DONE;
						end else begin
							state_q <= bblc_pkg::ST_CHECK;
						end
					end
				end
				// fits with a free slot, or nothing left to evict
				bblc_pkg::ST_CHECK: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if ((!over_c && cnt_q < FULL_CNT) || cnt_q == '0) begin
						state_q <= bblc_pkg::ST_FREE;
					end else begin
						iss_q   <= 1'b1;
						state_q <= bblc_pkg::ST_SCAN;
					end
				end
				// one read per cycle, compare on the registered read in the next cycle
				bblc_pkg::ST_SCAN: begin
					if (iss_q) begin
						if (idx_q == LAST_IDX) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (go_s1 && take_c) begin
						found_q <= 1'b1;
					end
					if (go_s1 && last_s1) begin
						state_q <= bblc_pkg::ST_RESOLVE;
					end
				end
				bblc_pkg::ST_RESOLVE: begin
					if (cmd_q == bblc_pkg::CMD_LOOKUP) begin
						if (found_q) begin
							res_status_q <= bblc_pkg::STATUS_HIT;
							res_slot_q   <= best_idx_q;
							res_hit_q    <= best_rec_q.plen;
						end
						state_q <= bblc_pkg::ST_DONE;
					end else begin
						valid_q[best_idx_q] <= 1'b0;
						used_q  <= used_q - best_rec_q.charge;
						cnt_q   <= cnt_q - 1'b1;
						ev_q    <= ev_q + 1'b1;
						state_q <= bblc_pkg::ST_CHECK;
					end
				end
				// lowest free slot, one valid bit per cycle
				bblc_pkg::ST_FREE: begin
					if (!valid_q[idx_q]) begin
						state_q <= bblc_pkg::ST_WRITE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				bblc_pkg::ST_WRITE: begin
					valid_q[idx_q] <= 1'b1;
					used_q       <= used_q + charge_q[31:0];
					cnt_q        <= cnt_q + 1'b1;
					seq_q        <= seq_q + 32'd1;
					res_status_q <= bblc_pkg::STATUS_INSERTED;
					res_slot_q   <= idx_q;
					state_q      <= bblc_pkg::ST_DONE;
				end
				// hand over to the result register
				bblc_pkg::ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_slot_q   <= 6'(res_slot_q);
						rsp_hit_q    <= res_hit_q;
						rsp_ev_q     <= 7'(ev_q);
						state_q      <= bblc_pkg::ST_IDLE;
					end
				end
				default: state_q <= bblc_pkg::ST_IDLE;
			endcase
		end
	end

	// checks
	`BBLC_ASSERT_NOW(a_cnt_matches_valid, clk, arst_n, 1'b1, (32'(cnt_q) == $countones(valid_q)), "entry count differs from valid bits")
	`BBLC_ASSERT_NEXT(a_xfer_leaves_idle, clk, arst_n, cmd_xfer, (state_q != bblc_pkg::ST_IDLE), "sequencer stayed idle after command transfer")
	`BBLC_ASSERT_NOW(a_write_has_room, clk, arst_n, (state_q == bblc_pkg::ST_WRITE), (cnt_q < FULL_CNT && !valid_q[idx_q]), "insert write into an occupied slot")
	`BBLC_ASSERT_NOW(a_victim_found, clk, arst_n, (state_q == bblc_pkg::ST_RESOLVE && cmd_q == bblc_pkg::CMD_INSERT), (found_q && valid_q[best_idx_q]), "eviction without a valid victim")

endmodule

// File: tb/bblc_directory_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bblc_directory_checker
// Watches command and result transfers of the cache directory, keeps its own
// copy of the directory and predicts each result, then compares the fields.
// ---------------------------------------------------------------------------
module bblc_directory_checker #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bblc_cmd_if                            cmd,
	bblc_rsp_if                            rsp,
	input  logic                           cfg_we,
	input  logic [bblc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bblc_pkg::BYTES_W-1:0]   cfg_data,
	output int                             fail_count,
	output int                             pending
);

	typedef struct packed {
		logic [bblc_pkg::STATUS_W-1:0] status;
		logic [bblc_pkg::SLOT_W-1:0]   slot;
		logic [bblc_pkg::PLEN_W-1:0]   hit_length;
		logic [bblc_pkg::EVCNT_W-1:0]  evicted_count;
	} dir_result_t;

	// shadow configuration
	logic [bblc_pkg::BYTES_W-1:0] budget;
	logic [bblc_pkg::BYTES_W-1:0] entry_limit;
	logic [bblc_pkg::OVH_W-1:0]   overhead;

	// shadow directory
	logic                         live    [ENTRIES];
	logic [bblc_pkg::KEY_W-1:0]   tag_of  [ENTRIES];
	logic [bblc_pkg::TIME_W-1:0]  stamp_of[ENTRIES];
	logic [bblc_pkg::BYTES_W-1:0] cost_of [ENTRIES];
	logic [31:0]                  seq_of  [ENTRIES];
	logic [bblc_pkg::PLEN_W-1:0]  len_of  [ENTRIES];
	logic [bblc_pkg::BYTES_W-1:0] bytes_used;
	logic [31:0]                  insert_count;

	dir_result_t expected_results[$];

	function automatic logic [31:0] insert_age(int s);
		return insert_count - seq_of[s];
	endfunction

	function automatic int lowest_free();
		for (int s = 0; s < ENTRIES; s++)
			if (!live[s]) return s;
		return -1;
	endfunction

	// oldest stamp, ties go to the newest insert
	function automatic int oldest_entry();
		int pick;
		pick = -1;
		for (int s = 0; s < ENTRIES; s++) begin
			if (!live[s]) continue;
			if (pick < 0 || stamp_of[s] < stamp_of[pick] ||
			    (stamp_of[s] == stamp_of[pick] && insert_age(s) < insert_age(pick)))
				pick = s;
		end
		return pick;
	endfunction

	task automatic run_command(input logic c, input logic [bblc_pkg::KEY_W-1:0] k,
	                           input logic [bblc_pkg::KLEN_W-1:0] kl,
	                           input logic [bblc_pkg::PLEN_W-1:0] pl,
	                           input logic [bblc_pkg::TIME_W-1:0] t, output dir_result_t r);
		int          pick;
		int          victim;
		logic [33:0] cost;
		r = '0;
		if (c == bblc_pkg::CMD_LOOKUP) begin
			pick = -1;
			for (int s = 0; s < ENTRIES; s++)
				if (live[s] && tag_of[s] == k && (pick < 0 || insert_age(s) < insert_age(pick)))
					pick = s;
			if (pick >= 0) begin
				stamp_of[pick] = t;
				r.status       = bblc_pkg::STATUS_HIT;
				r.slot         = bblc_pkg::SLOT_W'(pick);
				r.hit_length   = len_of[pick];
			end else begin
				r.status = bblc_pkg::STATUS_MISS;
			end
		end else begin
			cost = 34'(pl) + 34'(kl) + 34'd1 + 34'(overhead);
			if (cost > 34'(entry_limit)) begin
				r.status = bblc_pkg::STATUS_REJECTED;
			end else begin
				// evict until the charge fits and a slot is free
				forever begin
					if (34'(bytes_used) + cost <= 34'(budget) && lowest_free() >= 0) break;
					victim = oldest_entry();
					if (victim < 0) break;
					live[victim] = 1'b0;
					bytes_used   = bytes_used - cost_of[victim];
					r.evicted_count = r.evicted_count + 1'b1;
				end
				pick           = lowest_free();
				live[pick]     = 1'b1;
				tag_of[pick]   = k;
				stamp_of[pick] = t;
				cost_of[pick]  = cost[31:0];
				seq_of[pick]   = insert_count;
				len_of[pick]   = pl;
				insert_count   = insert_count + 32'd1;
				bytes_used     = bytes_used + cost[31:0];
				r.status       = bblc_pkg::STATUS_INSERTED;
				r.slot         = bblc_pkg::SLOT_W'(pick);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dir_result_t predicted;
		dir_result_t seen;
		dir_result_t want;
		if (!arst_n) begin
			budget       = bblc_pkg::RESET_CAPACITY;
			entry_limit  = bblc_pkg::RESET_MAX_ENTRY;
			overhead     = bblc_pkg::RESET_OVERHEAD;
			bytes_used   = '0;
			insert_count = '0;
			fail_count   = 0;
			pending      = 0;
			for (int s = 0; s < ENTRIES; s++) live[s] = 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					bblc_pkg::CFG_CAPACITY:  budget      = cfg_data;
					bblc_pkg::CFG_MAX_ENTRY: entry_limit = cfg_data;
					bblc_pkg::CFG_OVERHEAD:  overhead    = cfg_data[bblc_pkg::OVH_W-1:0];
					default: ;
				endcase
			end
			// command transfer
			if (cmd.valid && cmd.ready) begin
				run_command(cmd.command, cmd.key_tag, cmd.key_length, cmd.entry_length,
					cmd.now, predicted);
				expected_results.push_back(predicted);
			end
			// result transfer
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.status, rsp.slot, rsp.hit_length, rsp.evicted_count};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status=%0d slot=%0d len=%0d evicted=%0d",
							seen.status, seen.slot, seen.hit_length, seen.evicted_count);
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch at %0t: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime,
								want.status, want.slot, want.hit_length, want.evicted_count,
								seen.status, seen.slot, seen.hit_length, seen.evicted_count);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: tb/byte_budget_lru_cache_directory_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// byte_budget_lru_cache_directory_tb
// Drives lookups and inserts through several budget settings, with random
// stalls on both channels and one long result hold-off; the checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
module byte_budget_lru_cache_directory_tb;

	localparam int unsigned ENTRIES = 64;
	localparam logic [bblc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 20000000;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bblc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bblc_pkg::BYTES_W-1:0]   cfg_data;
	int                             fail_count;
	int                             pending;
	int                             results_seen = 0;
	int                             cycles;
	bit                             idling_on;
	bit                             holdoff_done;
	logic [bblc_pkg::TIME_W-1:0]    clock_now;
	logic [bblc_pkg::KEY_W-1:0]     key_base;

	bblc_cmd_if cmd_ch();
	bblc_rsp_if rsp_ch();

	byte_budget_lru_cache_directory #(.ENTRIES(ENTRIES)) uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bblc_directory_checker #(.ENTRIES(ENTRIES)) checker_i (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off
	always @(posedge clk)
		if (rsp_ch.valid && rsp_ch.ready) results_seen++;

	initial begin
		rsp_ch.ready = 1'b0;
		holdoff_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!holdoff_done && results_seen >= 300) begin
				rsp_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				holdoff_done = 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic c, input logic [bblc_pkg::KEY_W-1:0] k,
	                         input logic [bblc_pkg::KLEN_W-1:0] kl,
	                         input logic [bblc_pkg::PLEN_W-1:0] pl,
	                         input logic [bblc_pkg::TIME_W-1:0] t);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= c;
		cmd_ch.key_tag      <= k;
		cmd_ch.key_length   <= kl;
		cmd_ch.entry_length <= pl;
		cmd_ch.now          <= t;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// register write, only with nothing in flight
	task automatic write_reg(input logic [bblc_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [bblc_pkg::BYTES_W-1:0] val);
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (ENTRIES + 8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_budget(input logic [31:0] cap, input logic [31:0] lim,
	                          input logic [7:0] ovh);
		write_reg(bblc_pkg::CFG_CAPACITY, cap);
		write_reg(bblc_pkg::CFG_MAX_ENTRY, lim);
		write_reg(bblc_pkg::CFG_OVERHEAD, {24'h0, ovh});
	endtask

	// random traffic over a small key pool so hits and duplicates happen
	task automatic random_phase(input int count, input int pool);
		logic [bblc_pkg::KEY_W-1:0]  k;
		logic [bblc_pkg::KLEN_W-1:0] kl;
		logic [bblc_pkg::PLEN_W-1:0] pl;
		logic [bblc_pkg::TIME_W-1:0] t;
		for (int i = 0; i < count; i++) begin
			k  = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
				: key_base ^ bblc_pkg::KEY_W'($urandom_range(0, pool - 1));
			kl = ($urandom_range(0, 7) == 0) ? bblc_pkg::KLEN_W'($urandom)
				: bblc_pkg::KLEN_W'($urandom_range(0, 200));
			pl = ($urandom_range(0, 11) == 0) ? bblc_pkg::PLEN_W'($urandom)
				: bblc_pkg::PLEN_W'($urandom_range(0, 2000));
			clock_now = clock_now + $urandom_range(0, 3);
			t = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
			send_item($urandom_range(0, 1) ? bblc_pkg::CMD_INSERT : bblc_pkg::CMD_LOOKUP,
				k, kl, pl, t);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = bblc_pkg::CMD_LOOKUP;
		cmd_ch.key_tag      = '0;
		cmd_ch.key_length   = '0;
		cmd_ch.entry_length = '0;
		cmd_ch.now          = '0;
		idling_on           = 1'b1;
		clock_now           = 32'd1000;
		key_base            = {$urandom, $urandom};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset budget
		send_item(bblc_pkg::CMD_LOOKUP, '0, '0, '0, '0);                  // miss on empty
		send_item(bblc_pkg::CMD_INSERT, '1, 13'd10, 31'd100, 32'd5);
		send_item(bblc_pkg::CMD_LOOKUP, '1, '0, '0, 32'd6);               // hit
		send_item(bblc_pkg::CMD_INSERT, '1, 13'd20, 31'd200, 32'd7);      // duplicate key
		send_item(bblc_pkg::CMD_LOOKUP, '1, '0, '0, '1);                  // newest copy wins
		send_item(bblc_pkg::CMD_INSERT, '0, 13'd4096, 31'h7FFF_FFFF, '0); // rejected too large
		send_item(bblc_pkg::CMD_INSERT, '0, 13'h1FFF, 31'd0, '0);         // largest key length
		send_item(bblc_pkg::CMD_LOOKUP, '0, '0, '0, 32'd9);

		// directed: tiny budget, evictions, ties, over-budget entry
		set_budget(32'd1000, '1, 8'd255);
		write_reg(CFG_SPARE, '1);                                          // unused index
		send_item(bblc_pkg::CMD_INSERT, 64'h11, 13'd0, 31'd100, 32'd50);
		send_item(bblc_pkg::CMD_INSERT, 64'h22, 13'd0, 31'd100, 32'd50);   // same stamp
		send_item(bblc_pkg::CMD_INSERT, 64'h33, 13'd0, 31'd100, 32'd50);   // tie eviction
		send_item(bblc_pkg::CMD_LOOKUP, 64'h11, '0, '0, 32'd60);
		send_item(bblc_pkg::CMD_INSERT, 64'h44, 13'd0, 31'd5000, 32'd70);  // larger than budget
		send_item(bblc_pkg::CMD_INSERT, 64'h55, 13'd0, 31'd0, 32'd71);     // evicts the big one
		send_item(bblc_pkg::CMD_LOOKUP, 64'h44, '0, '0, 32'd72);
		set_budget('0, '0, 8'd0);
		send_item(bblc_pkg::CMD_INSERT, 64'h66, 13'd0, 31'd0, 32'd80);     // charge 1 over limit 0
		send_item(bblc_pkg::CMD_LOOKUP, 64'h55, '0, '0, 32'd81);

		// random phases across budget settings
		set_budget('1, '1, 8'd0);
		random_phase(190, 90);
		set_budget(32'd6000, 32'd3000, 8'd40);
		random_phase(190, 24);
		set_budget(32'd2500, '1, 8'd255);
		random_phase(190, 16);
		set_budget('0, '0, 8'd0);
		random_phase(40, 8);
		set_budget(bblc_pkg::RESET_CAPACITY, bblc_pkg::RESET_MAX_ENTRY, bblc_pkg::RESET_OVERHEAD);
		random_phase(190, 40);
		set_budget(32'd20000, 32'd20000, 8'd128);
		random_phase(150, 30);
		idling_on = 1'b0;
		random_phase(190, 30);
		cmd_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (4 * ENTRIES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bblc_pkg.sv
rtl/core/bblc_if.sv
rtl/core/byte_budget_lru_cache_directory.sv
tb/bblc_directory_checker.sv
tb/byte_budget_lru_cache_directory_tb.sv
